FILE: rtl/core/kpv_pkg.sv
// kpv_pkg: shared types, codes and operand map of the position/velocity filter
package kpv_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DATA_W = 32;
   localparam int OPND_W = 8;
   localparam int MEM_AW = 7;
   localparam int CSR_AW = 5;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [OPND_W-1:0] opnd_type;

   // configuration register indexes
   localparam logic [2:0] CSR_TIME_STEP     = 3'd0;
   localparam logic [2:0] CSR_PROCESS_NOISE = 3'd1;
   localparam logic [2:0] CSR_MEAS_NOISE_X  = 3'd2;
   localparam logic [2:0] CSR_MEAS_NOISE_Y  = 3'd3;
   localparam logic [2:0] CSR_INIT_POS_VAR  = 3'd4;
   localparam logic [2:0] CSR_INIT_VEL_VAR  = 3'd5;
   localparam logic [2:0] CSR_INIT_SPEED_Y  = 3'd6;

   // special operands, outside the scratch memory (top bit set)
   localparam opnd_type SP_ZERO = 8'h80;
   localparam opnd_type SP_ONE  = 8'h81;
   localparam opnd_type SP_DT   = 8'h82;
   localparam opnd_type SP_H2   = 8'h83;
   localparam opnd_type SP_AX   = 8'h84;
   localparam opnd_type SP_AY   = 8'h85;
   localparam opnd_type SP_MX   = 8'h86;
   localparam opnd_type SP_MY   = 8'h87;
   localparam opnd_type SP_Q    = 8'h88;
   localparam opnd_type SP_RX   = 8'h89;
   localparam opnd_type SP_RY   = 8'h8A;
   localparam opnd_type SP_IPV  = 8'h8B;
   localparam opnd_type SP_IVV  = 8'h8C;
   localparam opnd_type SP_ISY  = 8'h8D;

   // scratch memory map
   localparam int BASE_P  = 4;
   localparam int BASE_T  = 20;
   localparam int BASE_PP = 28;
   localparam int BASE_XP = 44;
   localparam int BASE_Y  = 48;
   localparam int A_S00   = 50;
   localparam int A_S11   = 51;
   localparam int A_DET   = 52;
   localparam int BASE_SI = 53;
   localparam int BASE_KG = 57;
   localparam int BASE_M  = 65;

   typedef enum logic [2:0] {
      TK_NONE,
      TK_ADD,
      TK_SUB,
      TK_MUL,
      TK_MSB
   } term_kind_type;

   typedef struct packed {
      term_kind_type kind;
      opnd_type      a;
      opnd_type      b;
   } term_type;

   typedef enum logic [3:0] {
      PH_RLE,
      PH_RLP,
      PH_XP,
      PH_T,
      PH_PP,
      PH_Y,
      PH_S,
      PH_DET,
      PH_CPE,
      PH_CPP,
      PH_SI,
      PH_KG,
      PH_EST,
      PH_M,
      PH_PN,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE_A,
      ST_ISSUE_B,
      ST_MUL,
      ST_ACC,
      ST_WRITE,
      ST_DIV_RD,
      ST_DIV_LD,
      ST_DIV_IT,
      ST_DIV_WR,
      ST_OUT
   } state_type;

   // element addresses
   function automatic opnd_type a_e(input logic [1:0] i);
      return opnd_type'(i);
   endfunction

   function automatic opnd_type a_p(input logic [1:0] i, input logic [1:0] j);
      return opnd_type'(BASE_P) + opnd_type'({i, j});
   endfunction

   function automatic opnd_type a_t(input logic [1:0] i, input logic [1:0] j);
      return i[1] ? a_p(i, j) : opnd_type'(BASE_T) + opnd_type'({i[0], j});
   endfunction

   function automatic opnd_type a_pp(input logic [1:0] i, input logic [1:0] j);
      return opnd_type'(BASE_PP) + opnd_type'({i, j});
   endfunction

   function automatic opnd_type a_xp(input logic [1:0] i);
      return opnd_type'(BASE_XP) + opnd_type'(i);
   endfunction

   function automatic opnd_type a_y(input logic i);
      return opnd_type'(BASE_Y) + opnd_type'(i);
   endfunction

   function automatic opnd_type a_si(input logic r, input logic c);
      return opnd_type'(BASE_SI) + opnd_type'({r, c});
   endfunction

   function automatic opnd_type a_kg(input logic [1:0] i, input logic j);
      return opnd_type'(BASE_KG) + opnd_type'({i, j});
   endfunction

   function automatic opnd_type a_m(input logic [1:0] i, input logic k);
      return opnd_type'(BASE_M) + opnd_type'({i, k});
   endfunction

   function automatic term_type mk(input term_kind_type k, input opnd_type a,
                                   input opnd_type b);
      term_type t;
      t.kind = k;
      t.a    = a;
      t.b    = b;
      return t;
   endfunction

   // term list of one element: terms are packed from the front
   function automatic term_type term_of(input phase_type ph, input logic [1:0] i,
                                        input logic [1:0] j, input logic [1:0] tc);
      term_type t [4];
      logic [1:0] hi_i;
      logic [1:0] hi_j;
      for (int n = 0; n < 4; n++) t[n] = mk(TK_NONE, SP_ZERO, SP_ZERO);
      hi_i = {1'b1, i[0]};
      hi_j = {1'b1, j[0]};
      case (ph)
         PH_RLE: t[0] = mk(TK_ADD, (i == 2'd3) ? SP_ISY : SP_ZERO, SP_ZERO);
         PH_RLP: t[0] = mk(TK_ADD, (i != j) ? SP_ZERO : (i[1] ? SP_IVV : SP_IPV),
                           SP_ZERO);
         PH_XP: begin
            t[0] = mk(TK_ADD, a_e(i), SP_ZERO);
            if (!i[1]) begin
               t[1] = mk(TK_MUL, SP_DT, a_e(hi_i));
               t[2] = mk(TK_MUL, SP_H2, i[0] ? SP_AY : SP_AX);
            end else begin
               t[1] = mk(TK_MUL, SP_DT, i[0] ? SP_AY : SP_AX);
            end
         end
         PH_T: begin
            t[0] = mk(TK_ADD, a_p({1'b0, i[0]}, j), SP_ZERO);
            t[1] = mk(TK_MUL, SP_DT, a_p(hi_i, j));
         end
         PH_PP: begin
            t[0] = mk(TK_ADD, a_t(i, j), SP_ZERO);
            if (!j[1]) begin
               t[1] = mk(TK_MUL, a_t(i, hi_j), SP_DT);
               if (i == j) t[2] = mk(TK_ADD, SP_Q, SP_ZERO);
            end else if (i == j) begin
               t[1] = mk(TK_ADD, SP_Q, SP_ZERO);
            end
         end
         PH_Y: begin
            t[0] = mk(TK_ADD, i[0] ? SP_MY : SP_MX, SP_ZERO);
            t[1] = mk(TK_SUB, a_xp(i), SP_ZERO);
         end
         PH_S: begin
            t[0] = mk(TK_ADD, a_pp(i, i), SP_ZERO);
            t[1] = mk(TK_ADD, i[0] ? SP_RY : SP_RX, SP_ZERO);
         end
         PH_DET: begin
            t[0] = mk(TK_MUL, opnd_type'(A_S00), opnd_type'(A_S11));
            t[1] = mk(TK_MSB, a_pp(2'd0, 2'd1), a_pp(2'd1, 2'd0));
         end
         PH_CPE: t[0] = mk(TK_ADD, a_xp(i), SP_ZERO);
         PH_CPP: t[0] = mk(TK_ADD, a_pp(i, j), SP_ZERO);
         PH_KG: begin
            t[0] = mk(TK_MUL, a_pp(i, 2'd0), a_si(1'b0, j[0]));
            t[1] = mk(TK_MUL, a_pp(i, 2'd1), a_si(1'b1, j[0]));
         end
         PH_EST: begin
            t[0] = mk(TK_ADD, a_xp(i), SP_ZERO);
            t[1] = mk(TK_MUL, a_kg(i, 1'b0), a_y(1'b0));
            t[2] = mk(TK_MUL, a_kg(i, 1'b1), a_y(1'b1));
         end
         PH_M: begin
            t[0] = mk(TK_ADD, (i == j) ? SP_ONE : SP_ZERO, SP_ZERO);
            t[1] = mk(TK_SUB, a_kg(i, j[0]), SP_ZERO);
         end
         PH_PN: begin
            t[0] = mk(TK_MUL, a_m(i, 1'b0), a_pp(2'd0, j));
            t[1] = mk(TK_MUL, a_m(i, 1'b1), a_pp(2'd1, j));
            if (i[1]) t[2] = mk(TK_ADD, a_pp(i, j), SP_ZERO);
         end
         default: t[0] = mk(TK_NONE, SP_ZERO, SP_ZERO);
      endcase
      return t[tc];
   endfunction

   // destination of one element
   function automatic opnd_type dst_of(input phase_type ph, input logic [1:0] i,
                                       input logic [1:0] j);
      opnd_type d;
      case (ph)
         PH_RLE, PH_CPE, PH_EST: d = a_e(i);
         PH_RLP, PH_CPP, PH_PN:  d = a_p(i, j);
         PH_XP:                  d = a_xp(i);
         PH_T:                   d = a_t({1'b0, i[0]}, j);
         PH_PP:                  d = a_pp(i, j);
         PH_Y:                   d = a_y(i[0]);
         PH_S:                   d = opnd_type'(A_S00) + opnd_type'(i[0]);
         PH_DET:                 d = opnd_type'(A_DET);
         PH_SI:                  d = opnd_type'(BASE_SI) + opnd_type'(i);
         PH_KG:                  d = a_kg(i, j[0]);
         PH_M:                   d = a_m(i, j[0]);
         default:                d = SP_ZERO;
      endcase
      return d;
   endfunction

   // numerator of each inverse element: adj(S) order s11, -s01, -s10, s00
   function automatic opnd_type div_num(input logic [1:0] i);
      opnd_type d;
      case (i)
         2'd0:    d = opnd_type'(A_S11);
         2'd1:    d = a_pp(2'd0, 2'd1);
         2'd2:    d = a_pp(2'd1, 2'd0);
         default: d = opnd_type'(A_S00);
      endcase
      return d;
   endfunction

   function automatic logic [1:0] last_row(input phase_type ph);
      logic [1:0] r;
      case (ph)
         PH_T, PH_Y, PH_S: r = 2'd1;
         PH_DET:           r = 2'd0;
         default:          r = 2'd3;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] last_col(input phase_type ph);
      logic [1:0] c;
      case (ph)
         PH_RLP, PH_T, PH_PP, PH_CPP, PH_PN: c = 2'd3;
         PH_KG, PH_M:                        c = 2'd1;
         default:                            c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic phase_type next_phase(input phase_type ph, input logic sing);
      phase_type n;
      case (ph)
         PH_RLE:  n = PH_RLP;
         PH_XP:   n = PH_T;
         PH_T:    n = PH_PP;
         PH_PP:   n = PH_Y;
         PH_Y:    n = PH_S;
         PH_S:    n = PH_DET;
         PH_DET:  n = sing ? PH_CPE : PH_SI;
         PH_CPE:  n = PH_CPP;
         PH_SI:   n = PH_KG;
         PH_KG:   n = PH_EST;
         PH_EST:  n = PH_M;
         PH_M:    n = PH_PN;
         default: n = PH_DONE;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/core/kpv_req_if.sv
// kpv_req_if: input channel carrying one filter transaction
interface kpv_req_if import kpv_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     action;
   data_type accel_x;
   data_type accel_y;
   data_type meas_x;
   data_type meas_y;

   modport source (output valid, action, accel_x, accel_y, meas_x, meas_y, input ready);
   modport sink (input valid, action, accel_x, accel_y, meas_x, meas_y, output ready);
endinterface

FILE: rtl/core/kpv_rsp_if.sv
// kpv_rsp_if: result channel carrying the updated estimate
interface kpv_rsp_if import kpv_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type pos_x;
   data_type pos_y;
   data_type vel_x;
   data_type vel_y;
   logic     singular;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, singular, input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, singular, output ready);
endinterface

FILE: rtl/core/kalman_position_velocity_filter.sv
// kalman_position_velocity_filter: four-state track filter on a shared multiply unit
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    action, accel_x, accel_y, meas_x, meas_y
//   rsp_chan  out        valid/ready    pos_x, pos_y, vel_x, vel_y, singular
//   csr_*     in         apb write/read time_step .. init_speed_y at 4*index
//
// a filter step computes one product at a time, each through the issue, multiply and
// accumulate states on the shared multiplier and the single scratch memory port, plus four
// divisions of FRAC_BITS+34 steps; a singular step skips the divisions and the gain.
// after reset a reload pass fills the memory before the first transaction.
// a finished result waits in the output register while the next transaction is taken.
module kalman_position_velocity_filter import kpv_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   kpv_req_if.sink           req_chan,
   kpv_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int ACC_W = 64;
   localparam int NW = FRAC_BITS + 34;
   localparam int REM_W = 33;
   localparam int CNT_W = $clog2(NW + 1);
   localparam int MEM_DEPTH = 1 << MEM_AW;
   localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
   localparam data_type ONE = data_type'(ONE64);
   localparam logic [16:0] TS_RESET = 17'((ONE64 + 64'd5) / 64'd10);
   localparam logic [30:0] R_RESET = 31'(ONE64 * 64'd2);
   localparam logic [30:0] IPV_RESET = 31'(ONE64 * 64'd5);
   localparam logic [30:0] IVV_RESET = 31'(ONE64 * 64'd2);
   localparam logic [31:0] ISY_RESET = 32'(ONE64 * 64'd20);

   // rounded product, half away from zero
   function automatic logic signed [ACC_W-1:0] rnd_prod(input logic signed [63:0] p);
      logic [63:0] m;
      m = p[63] ? 64'(-p) : 64'(p);
      m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return p[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic data_type sat32(input logic signed [ACC_W-1:0] v);
      data_type r;
      if (v > ACC_W'(64'sh7FFFFFFF)) r = 32'sh7FFFFFFF;
      else if (v < -ACC_W'(64'sh80000000)) r = 32'sh80000000;
      else r = data_type'(v);
      return r;
   endfunction

   // configuration registers
   logic [16:0] time_step_ff;
   logic [30:0] proc_noise_ff;
   logic [30:0] noise_x_ff;
   logic [30:0] noise_y_ff;
   logic [30:0] pos_var_ff;
   logic [30:0] vel_var_ff;
   data_type    speed_y_ff;
   logic [31:0] h2_ff;
   logic [34:0] dt_sq;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // sequencer
   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  col_ff, col_in;
   logic [1:0]  tc_ff, tc_in;
   logic [1:0]  tc_nx;
   logic        boot_ff, boot_in;
   logic        sing_ff, sing_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   data_type    opa_ff, opa_in;
   logic signed [63:0] prod_ff, prod_in;
   data_type    det_ff, det_in;
   data_type    ax_ff, ax_in, ay_ff, ay_in, mx_ff, mx_in, my_ff, my_in;

   // divider
   logic [NW-1:0]    num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             qneg_ff, qneg_in;

   // result
   data_type est_ff [4];
   logic     rsp_valid_ff, rsp_valid_in;
   data_type rsp_pos_x_ff, rsp_pos_y_ff, rsp_vel_x_ff, rsp_vel_y_ff;
   logic     rsp_sing_ff;
   logic     out_load;

   // scratch memory
   logic [31:0] mem [MEM_DEPTH];
   logic [31:0] rdata_ff;
   data_type    spec_ff;
   logic        spec_sel_ff;
   opnd_type    rd_addr;
   data_type    spec_val;
   logic        wr_en;
   opnd_type    wr_addr;
   data_type    wr_data;

   // decoded control
   term_type    term;
   term_type    term_nx;
   logic        last_term;
   data_type    opval;
   data_type    wr_val;
   logic signed [ACC_W-1:0] rnd;
   opnd_type    dst;
   logic        elem_last;
   phase_type   ph_nx;
   logic        sing_now;
   state_type   adv_state;
   phase_type   adv_phase;
   logic [1:0]  adv_row;
   logic [1:0]  adv_col;
   logic        adv_done;

   // divider datapath
   logic signed [32:0] n_ext, n_sgn, d_ext;
   logic [32:0]  un, ud;
   logic [33:0]  d2;
   logic [33:0]  rem_sh;
   logic         qbit;
   data_type     q_sat;

   // apb port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_paddr[4:2];

   always_comb begin
      case (csr_idx)
         CSR_TIME_STEP:     csr_prdata = {15'd0, time_step_ff};
         CSR_PROCESS_NOISE: csr_prdata = {1'b0, proc_noise_ff};
         CSR_MEAS_NOISE_X:  csr_prdata = {1'b0, noise_x_ff};
         CSR_MEAS_NOISE_Y:  csr_prdata = {1'b0, noise_y_ff};
         CSR_INIT_POS_VAR:  csr_prdata = {1'b0, pos_var_ff};
         CSR_INIT_VEL_VAR:  csr_prdata = {1'b0, vel_var_ff};
         CSR_INIT_SPEED_Y:  csr_prdata = speed_y_ff;
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= TS_RESET;
         proc_noise_ff <= 31'd0;
         noise_x_ff    <= R_RESET;
         noise_y_ff    <= R_RESET;
         pos_var_ff    <= IPV_RESET;
         vel_var_ff    <= IVV_RESET;
         speed_y_ff    <= ISY_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_TIME_STEP:     time_step_ff  <= csr_pwdata[16:0];
            CSR_PROCESS_NOISE: proc_noise_ff <= csr_pwdata[30:0];
            CSR_MEAS_NOISE_X:  noise_x_ff    <= csr_pwdata[30:0];
            CSR_MEAS_NOISE_Y:  noise_y_ff    <= csr_pwdata[30:0];
            CSR_INIT_POS_VAR:  pos_var_ff    <= csr_pwdata[30:0];
            CSR_INIT_VEL_VAR:  vel_var_ff    <= csr_pwdata[30:0];
            CSR_INIT_SPEED_Y:  speed_y_ff    <= csr_pwdata;
            default:           time_step_ff  <= time_step_ff;
         endcase
      end
   end

   // dt^2/2, kept up to date from the time step register
   assign dt_sq = 35'(time_step_ff) * 35'(time_step_ff);

   always_ff @(posedge clock) begin
      h2_ff <= 32'((dt_sq + 35'(ONE64)) >> (FRAC_BITS + 1));
   end

   // special operand values
   always_comb begin
      case (rd_addr)
         SP_ONE:  spec_val = ONE;
         SP_DT:   spec_val = data_type'({15'd0, time_step_ff});
         SP_H2:   spec_val = data_type'(h2_ff);
         SP_AX:   spec_val = ax_ff;
         SP_AY:   spec_val = ay_ff;
         SP_MX:   spec_val = mx_ff;
         SP_MY:   spec_val = my_ff;
         SP_Q:    spec_val = data_type'({1'b0, proc_noise_ff});
         SP_RX:   spec_val = data_type'({1'b0, noise_x_ff});
         SP_RY:   spec_val = data_type'({1'b0, noise_y_ff});
         SP_IPV:  spec_val = data_type'({1'b0, pos_var_ff});
         SP_IVV:  spec_val = data_type'({1'b0, vel_var_ff});
         SP_ISY:  spec_val = speed_y_ff;
         default: spec_val = '0;
      endcase
   end

   // scratch memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[MEM_AW-1:0]] <= wr_data;
      rdata_ff    <= mem[rd_addr[MEM_AW-1:0]];
      spec_ff     <= spec_val;
      spec_sel_ff <= rd_addr[OPND_W-1];
   end

   // term decode and element bookkeeping
   assign tc_nx     = tc_ff + 2'd1;
   assign term      = term_of(phase_ff, row_ff, col_ff, tc_ff);
   assign term_nx   = term_of(phase_ff, row_ff, col_ff, tc_nx);
   assign last_term = (tc_ff == 2'd3) || (term_nx.kind == TK_NONE);
   assign opval     = spec_sel_ff ? spec_ff : data_type'(rdata_ff);
   assign wr_val    = sat32(acc_ff);
   assign rnd       = rnd_prod(prod_ff);
   assign dst       = dst_of(phase_ff, row_ff, col_ff);
   assign elem_last = (row_ff == last_row(phase_ff)) && (col_ff == last_col(phase_ff));
   assign sing_now  = (phase_ff == PH_DET) ? (wr_val == '0) : sing_ff;
   assign ph_nx     = next_phase(phase_ff, sing_now);

   // next element, next phase
   always_comb begin
      adv_phase = phase_ff;
      adv_row   = row_ff;
      adv_col   = col_ff;
      adv_done  = 1'b0;
      adv_state = (phase_ff == PH_SI) ? ST_DIV_RD : ST_ISSUE_A;
      if (elem_last) begin
         adv_phase = ph_nx;
         adv_row   = 2'd0;
         adv_col   = 2'd0;
         if (ph_nx == PH_DONE) begin
            adv_done  = 1'b1;
            adv_state = boot_ff ? ST_IDLE : ST_OUT;
         end else if (ph_nx == PH_SI) begin
            adv_state = ST_DIV_RD;
         end else begin
            adv_state = ST_ISSUE_A;
         end
      end else if (col_ff == last_col(phase_ff)) begin
         adv_col = 2'd0;
         adv_row = row_ff + 2'd1;
      end else begin
         adv_col = col_ff + 2'd1;
      end
   end

   // divider datapath
   assign n_ext  = 33'(opval);
   assign n_sgn  = (row_ff[0] ^ row_ff[1]) ? -n_ext : n_ext;
   assign d_ext  = 33'(det_ff);
   assign un     = n_sgn[32] ? 33'(-n_sgn) : 33'(n_sgn);
   assign ud     = d_ext[32] ? 33'(-d_ext) : 33'(d_ext);
   assign d2     = {ud, 1'b0};
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign qbit   = (rem_sh >= d2);

   always_comb begin
      if (!qneg_ff) begin
         q_sat = (num_ff > NW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : data_type'(num_ff[31:0]);
      end else begin
         q_sat = (num_ff > NW'(33'h080000000)) ? 32'sh80000000
                                               : data_type'(32'(-num_ff[31:0]));
      end
   end

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   // sequencer next state and outputs
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      tc_in     = tc_ff;
      boot_in   = boot_ff;
      sing_in   = sing_ff;
      acc_in    = acc_ff;
      opa_in    = opa_ff;
      prod_in   = prod_ff;
      det_in    = det_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      qneg_in   = qneg_ff;
      rd_addr   = term.a;
      wr_en     = 1'b0;
      wr_addr   = dst;
      wr_data   = wr_val;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               ax_in    = req_chan.accel_x;
               ay_in    = req_chan.accel_y;
               mx_in    = req_chan.meas_x;
               my_in    = req_chan.meas_y;
               sing_in  = 1'b0;
               phase_in = req_chan.action ? PH_RLE : PH_XP;
               row_in   = 2'd0;
               col_in   = 2'd0;
               tc_in    = 2'd0;
               acc_in   = '0;
               state_in = ST_ISSUE_A;
            end
         end

         ST_ISSUE_A: begin
            rd_addr  = term.a;
            state_in = ST_ISSUE_B;
         end

         ST_ISSUE_B: begin
            if (term.kind == TK_MUL || term.kind == TK_MSB) begin
               opa_in   = opval;
               rd_addr  = term.b;
               state_in = ST_MUL;
            end else begin
               if (term.kind == TK_ADD) acc_in = acc_ff + ACC_W'(opval);
               else if (term.kind == TK_SUB) acc_in = acc_ff - ACC_W'(opval);
               if (last_term) begin
                  state_in = ST_WRITE;
               end else begin
                  tc_in    = tc_nx;
                  state_in = ST_ISSUE_A;
               end
            end
         end

         ST_MUL: begin
            prod_in  = opa_ff * opval;
            state_in = ST_ACC;
         end

         ST_ACC: begin
            acc_in = (term.kind == TK_MSB) ? acc_ff - rnd : acc_ff + rnd;
            if (last_term) begin
               state_in = ST_WRITE;
            end else begin
               tc_in    = tc_nx;
               state_in = ST_ISSUE_A;
            end
         end

         ST_WRITE: begin
            wr_en = 1'b1;
            if (phase_ff == PH_DET) begin
               det_in  = wr_val;
               sing_in = (wr_val == '0);
            end
            acc_in   = '0;
            tc_in    = 2'd0;
            phase_in = adv_phase;
            row_in   = adv_row;
            col_in   = adv_col;
            state_in = adv_state;
            if (adv_done) boot_in = 1'b0;
         end

         ST_DIV_RD: begin
            rd_addr  = div_num(row_ff);
            state_in = ST_DIV_LD;
         end

         // numerator scaled by 2^(F+1) plus |det|, over 2|det|
         ST_DIV_LD: begin
            qneg_in  = n_sgn[32] ^ det_ff[DATA_W-1];
            num_in   = (NW'(un) << (FRAC_BITS + 1)) + NW'(ud);
            rem_in   = '0;
            cnt_in   = CNT_W'(NW);
            state_in = ST_DIV_IT;
         end

         ST_DIV_IT: begin
            rem_in = qbit ? REM_W'(rem_sh - d2) : REM_W'(rem_sh);
            num_in = {num_ff[NW-2:0], qbit};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) state_in = ST_DIV_WR;
         end

         ST_DIV_WR: begin
            wr_en    = 1'b1;
            wr_data  = q_sat;
            phase_in = adv_phase;
            row_in   = adv_row;
            col_in   = adv_col;
            state_in = adv_state;
         end

         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ISSUE_A;
         phase_ff     <= PH_RLE;
         row_ff       <= 2'd0;
         col_ff       <= 2'd0;
         tc_ff        <= 2'd0;
         boot_ff      <= 1'b1;
         sing_ff      <= 1'b0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         tc_ff        <= tc_in;
         boot_ff      <= boot_in;
         sing_ff      <= sing_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      prod_ff <= prod_in;
      det_ff  <= det_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      qneg_ff <= qneg_in;
      if (wr_en && (wr_addr[MEM_AW-1:2] == '0)) est_ff[wr_addr[1:0]] <= wr_data;
      if (out_load) begin
         rsp_pos_x_ff <= est_ff[0];
         rsp_pos_y_ff <= est_ff[1];
         rsp_vel_x_ff <= est_ff[2];
         rsp_vel_y_ff <= est_ff[3];
         rsp_sing_ff  <= sing_ff;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.pos_x    = rsp_pos_x_ff;
   assign rsp_chan.pos_y    = rsp_pos_y_ff;
   assign rsp_chan.vel_x    = rsp_vel_x_ff;
   assign rsp_chan.vel_y    = rsp_vel_y_ff;
   assign rsp_chan.singular = rsp_sing_ff;

endmodule

FILE: tb/kalman_position_velocity_filter_tb.sv
`timescale 1ns / 1ps
// kalman_position_velocity_filter_tb: self-checking bench for the track filter, with its own predictor
module kalman_position_velocity_filter_tb;
   import kpv_pkg::*;

   localparam int  FB          = FRAC_BITS_DEFAULT;
   localparam longint ONE_Q    = longint'(1) << FB;
   localparam int  STALL_LIMIT = 20000;
   localparam int  QUIET_FROM  = 640;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   typedef int mat4_t [4][4];

   typedef struct {
      data_type pos_x;
      data_type pos_y;
      data_type vel_x;
      data_type vel_y;
      logic     singular;
   } estimate_rec;

   typedef struct {
      logic        singular_setup;
      logic        action;
      int          ax, ay, mx, my;
      logic        known;
      estimate_rec want;
   } stim_row;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   kpv_req_if req_chan ();
   kpv_rsp_if rsp_chan ();

   kalman_position_velocity_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor copy of the registers and the track state
   int    cfg_dt, cfg_q, cfg_rx, cfg_ry, cfg_pos_var, cfg_vel_var, cfg_speed_y;
   int    trk_x [4];
   mat4_t trk_p;

   estimate_rec expected_estimates [$];
   int  fails;
   int  sent_items;
   logic quiet;
   int  stall_left;
   int  idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clip32(input longint v);
      if (v > longint'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
      if (v < -longint'(32'sh80000000) - 0 && v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // product rounded half away from zero, not saturated
   function automatic longint q_mul(input int a, input int b);
      longint p, m;
      p = longint'(a) * longint'(b);
      m = (p < 0) ? -p : p;
      m = (m + (longint'(1) << (FB - 1))) >>> FB;
      return (p < 0) ? -m : m;
   endfunction

   // fixed point quotient, rounded half away from zero
   function automatic int q_div(input longint n, input longint d);
      logic   neg;
      longint un, ud, q;
      neg = (n < 0) != (d < 0);
      un  = (n < 0) ? -n : n;
      ud  = (d < 0) ? -d : d;
      q   = ((un << FB) * 2 + ud) / (2 * ud);
      return neg ? clip32(-q) : clip32(q);
   endfunction

   function automatic mat4_t mat_prod(input mat4_t l, input mat4_t r, input longint diag);
      mat4_t  o;
      longint s;
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) begin
            s = (i == j) ? diag : 0;
            for (int k = 0; k < 4; k++) s += q_mul(l[i][k], r[k][j]);
            o[i][j] = clip32(s);
         end
      return o;
   endfunction

   function automatic void reload_track();
      trk_x = '{0, 0, 0, cfg_speed_y};
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) trk_p[i][j] = 0;
      trk_p[0][0] = cfg_pos_var;
      trk_p[1][1] = cfg_pos_var;
      trk_p[2][2] = cfg_vel_var;
      trk_p[3][3] = cfg_vel_var;
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [31:0] v);
      case (idx)
         CSR_TIME_STEP:     cfg_dt      = int'(v & 32'h1FFFF);
         CSR_PROCESS_NOISE: cfg_q       = int'(v & 32'h7FFFFFFF);
         CSR_MEAS_NOISE_X:  cfg_rx      = int'(v & 32'h7FFFFFFF);
         CSR_MEAS_NOISE_Y:  cfg_ry      = int'(v & 32'h7FFFFFFF);
         CSR_INIT_POS_VAR:  cfg_pos_var = int'(v & 32'h7FFFFFFF);
         CSR_INIT_VEL_VAR:  cfg_vel_var = int'(v & 32'h7FFFFFFF);
         CSR_INIT_SPEED_Y:  cfg_speed_y = int'(v);
         default: ;
      endcase
   endfunction

   // one filter transaction: advance the track and give the new estimate
   function automatic estimate_rec track_update(input logic action, input int ax, input int ay,
                                                input int mx, input int my);
      estimate_rec r;
      int    dt, h2, s00, s01, s10, s11, det, y0, y1;
      int    xp [4];
      int    si [2][2];
      int    kg [4][2];
      mat4_t a, at, t, pp, m;
      r.singular = 1'b0;
      if (action) begin
         reload_track();
      end else begin
         dt = cfg_dt;
         h2 = int'((longint'(cfg_dt) * longint'(cfg_dt) + ONE_Q) >>> (FB + 1));
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) a[i][j] = (i == j) ? int'(ONE_Q) : 0;
         a[0][2] = dt;
         a[1][3] = dt;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) at[i][j] = a[j][i];
         xp[0] = clip32(longint'(trk_x[0]) + q_mul(dt, trk_x[2]) + q_mul(h2, ax));
         xp[1] = clip32(longint'(trk_x[1]) + q_mul(dt, trk_x[3]) + q_mul(h2, ay));
         xp[2] = clip32(longint'(trk_x[2]) + q_mul(dt, ax));
         xp[3] = clip32(longint'(trk_x[3]) + q_mul(dt, ay));
         t  = mat_prod(a, trk_p, 0);
         pp = mat_prod(t, at, longint'(cfg_q));
         y0 = clip32(longint'(mx) - xp[0]);
         y1 = clip32(longint'(my) - xp[1]);
         s00 = clip32(longint'(pp[0][0]) + cfg_rx);
         s01 = pp[0][1];
         s10 = pp[1][0];
         s11 = clip32(longint'(pp[1][1]) + cfg_ry);
         det = clip32(q_mul(s00, s11) - q_mul(s01, s10));
         if (det == 0) begin
            // innovation covariance not invertible: keep the prediction
            r.singular = 1'b1;
            trk_x = xp;
            trk_p = pp;
         end else begin
            si[0][0] = q_div(s11, det);
            si[0][1] = q_div(-longint'(s01), det);
            si[1][0] = q_div(-longint'(s10), det);
            si[1][1] = q_div(s00, det);
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 2; j++)
                  kg[i][j] = clip32(q_mul(pp[i][0], si[0][j]) + q_mul(pp[i][1], si[1][j]));
            for (int i = 0; i < 4; i++)
               trk_x[i] = clip32(longint'(xp[i]) + q_mul(kg[i][0], y0) + q_mul(kg[i][1], y1));
            for (int i = 0; i < 4; i++)
               for (int k = 0; k < 4; k++)
                  m[i][k] = clip32(((i == k) ? ONE_Q : 0) - ((k < 2) ? longint'(kg[i][k]) : 0));
            trk_p = mat_prod(m, pp, 0);
         end
      end
      r.pos_x = trk_x[0];
      r.pos_y = trk_x[1];
      r.vel_x = trk_x[2];
      r.vel_y = trk_x[3];
      return r;
   endfunction

   // register write: setup cycle then access cycle
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      apply_csr(idx, v);
   endtask

   task automatic wait_drained();
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // present one transaction and hold it until taken
   task automatic send_item(input logic action, input int ax, input int ay, input int mx,
                            input int my, input logic known, input estimate_rec want);
      estimate_rec p;
      req_chan.valid   <= 1'b1;
      req_chan.action  <= action;
      req_chan.accel_x <= ax;
      req_chan.accel_y <= ay;
      req_chan.meas_x  <= mx;
      req_chan.meas_y  <= my;
      do @(posedge clock); while (!req_chan.ready);
      p = track_update(action, ax, ay, mx, my);
      expected_estimates.push_back(known ? want : p);
      sent_items++;
      if (sent_items >= QUIET_FROM) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // result side: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= 0;
      end else if (quiet) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left     <= $urandom_range(0, 6);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      estimate_rec e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_estimates.size() == 0) begin
            $error("unexpected result transaction");
            fails++;
         end else begin
            e = expected_estimates.pop_front();
            if (rsp_chan.pos_x !== e.pos_x) begin
               $error("pos_x expected %0d got %0d", e.pos_x, rsp_chan.pos_x); fails++;
            end
            if (rsp_chan.pos_y !== e.pos_y) begin
               $error("pos_y expected %0d got %0d", e.pos_y, rsp_chan.pos_y); fails++;
            end
            if (rsp_chan.vel_x !== e.vel_x) begin
               $error("vel_x expected %0d got %0d", e.vel_x, rsp_chan.vel_x); fails++;
            end
            if (rsp_chan.vel_y !== e.vel_y) begin
               $error("vel_y expected %0d got %0d", e.vel_y, rsp_chan.vel_y); fails++;
            end
            if (rsp_chan.singular !== e.singular) begin
               $error("singular expected %0d got %0d", e.singular, rsp_chan.singular); fails++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus
   initial begin
      stim_row     rows [$];
      estimate_rec none, rl;
      int          ax, ay, mx, my, pick;
      logic [31:0] v [7];
      none = '{0, 0, 0, 0, 1'b0};
      rl   = '{0, 0, 0, 32'sd1310720, 1'b0};
      fails = 0; sent_items = 0; quiet = 1'b0; idle_cycles = 0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0; req_chan.action <= 1'b0;
      req_chan.accel_x <= 0; req_chan.accel_y <= 0;
      req_chan.meas_x <= 0; req_chan.meas_y <= 0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      cfg_dt = 6554; cfg_q = 0; cfg_rx = 131072; cfg_ry = 131072;
      cfg_pos_var = 327680; cfg_vel_var = 131072; cfg_speed_y = 1310720;
      reload_track();

      // directed rows: defaults first, then a zero-variance singular setup with dt zero
      rows = '{
         '{0, 1, 0, 0, 0, 0, 1, rl},
         '{0, 0, 0, 0, 0, 0, 0, none},
         '{0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, none},
         '{0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, none},
         '{0, 0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, none},
         '{0, 0, 0, 0, 32'sh80000000, 32'sh80000000, 0, none},
         '{0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, none},
         '{0, 1, -1, -1, -1, -1, 1, rl},
         '{0, 0, -1, -1, -1, -1, 0, none},
         '{0, 0, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 0, none},
         '{0, 0, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 0, none},
         '{1, 1, 0, 0, 0, 0, 1, rl},
         '{0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 32'sd1310720, 1'b1}},
         '{0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 1,
           '{0, 0, 0, 32'sd1310720, 1'b1}},
         '{0, 0, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 1, '{0, 0, 0, 32'sd1310720, 1'b1}}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[n]) begin
         if (rows[n].singular_setup) begin
            req_chan.valid <= 1'b0;
            wait_drained();
            csr_write(CSR_TIME_STEP, 32'd0);
            csr_write(CSR_PROCESS_NOISE, 32'd0);
            csr_write(CSR_MEAS_NOISE_X, 32'd1);
            csr_write(CSR_MEAS_NOISE_Y, 32'd1);
            csr_write(CSR_INIT_POS_VAR, 32'd0);
            csr_write(CSR_INIT_VEL_VAR, 32'd0);
         end
         send_item(rows[n].action, rows[n].ax, rows[n].ay, rows[n].mx, rows[n].my,
                   rows[n].known, rows[n].want);
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < 8; ph++) begin
         req_chan.valid <= 1'b0;
         wait_drained();
         case (ph)
            0: v = '{32'd65536, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
            1: v = '{32'd1, 32'd0, 32'd1, 32'd1, 32'd0, 32'd0, 32'h80000000};
            2: v = '{32'd6554, 32'd0, 32'd131072, 32'd131072,
                     32'd327680, 32'd131072, 32'd1310720};
            default: begin
               v[0] = $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(655, 13107);
               v[1] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536);
               v[2] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 20);
               v[3] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 1 << 20);
               v[4] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22);
               v[5] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20);
               v[6] = $urandom;
            end
         endcase
         for (int r = 0; r < 7; r++) csr_write(r[2:0], v[r]);
         if (ph == 3) csr_write(CSR_UNUSED, $urandom);
         send_item(1'b1, 0, 0, 0, 0, 1'b0, none);
         for (int n = 0; n < 85; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send_item(1'b1, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
            end else if (pick < 22) begin
               send_item(1'b0, $urandom, $urandom, $urandom, $urandom, 1'b0, none);
            end else begin
               // plausible track: small accelerations, fixes close to the estimate
               ax = int'($urandom_range(0, 1 << 21)) - (1 << 20);
               ay = int'($urandom_range(0, 1 << 21)) - (1 << 20);
               mx = clip32(longint'(trk_x[0]) + int'($urandom_range(0, 1 << 19)) - (1 << 18));
               my = clip32(longint'(trk_x[1]) + int'($urandom_range(0, 1 << 19)) - (1 << 18));
               send_item(1'b0, ax, ay, mx, my, 1'b0, none);
            end
         end
      end

      req_chan.valid <= 1'b0;
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fails == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
